// File: rtl/wave_table_point_generator_core_defines.svh
// Assertion macros shared by the wave table point generator RTL.
`ifndef WAVE_TABLE_POINT_GENERATOR_CORE_DEFINES_SVH
`define WAVE_TABLE_POINT_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WTPG_ASSERT_NOW(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("wtpg: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WTPG_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("wtpg: next-cycle check failed");

`endif

// File: rtl/wtpg_pkg.sv
// Types and constants of the wave table point generator.
package wtpg_pkg;

	localparam int INDEX_BITS_DEF          = 16;
	localparam int LEVEL_FRACTION_BITS_DEF = 24;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int PERIOD_W    = 17;
	localparam int OFFSET_W    = 16;
	localparam int SAMPLE_W    = 32;

	// Q30 fixed point used by the sine path
	localparam int Q_FRAC = 30;
	localparam int U_W    = Q_FRAC + 1;
	localparam int X_W    = 31;
	localparam int X2_W   = 32;
	localparam int B_W    = 31;

	localparam logic [U_W-1:0] Q30_ONE     = U_W'(1) << Q_FRAC;
	localparam logic [X_W-1:0] HALF_PI_Q30 = 31'd1686629713;

	localparam int TAYLOR_TERMS = 7;

	localparam logic [PERIOD_W-1:0]        PERIOD_RST = 17'd1024;
	localparam logic signed [SAMPLE_W-1:0] HIGH_RST   = 32'sd32767;
	localparam logic signed [SAMPLE_W-1:0] S16_MIN    = -32'sd32768;
	localparam logic signed [SAMPLE_W-1:0] S16_MAX    = 32'sd32767;
	localparam logic signed [SAMPLE_W-1:0] S32_MIN    = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] S32_MAX    = 32'sh7fff_ffff;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WAVE_KIND     = 3'd0,
		REG_OUT_FORMAT    = 3'd1,
		REG_PERIOD_LENGTH = 3'd2,
		REG_START_OFFSET  = 3'd3,
		REG_LOW_LEVEL     = 3'd4,
		REG_HIGH_LEVEL    = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		WAVE_SINE     = 1'b0,
		WAVE_TRIANGLE = 1'b1
	} wave_kind_t;

	typedef enum logic {
		FMT_S16 = 1'b0,
		FMT_S32 = 1'b1
	} out_format_t;

endpackage

// File: rtl/wtpg_div_cell.sv
// One restoring division step: shifts a numerator bit into the remainder.
module wtpg_div_cell #(
	parameter int NUM_W  = 2,
	parameter int DIV_W  = 17,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  logic [DIV_W-1:0]  divisor,
	input  logic [DIV_W-1:0]  rem_i,
	input  logic [NUM_W-1:0]  num_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              valid_o,
	output logic [DIV_W-1:0]  rem_o,
	output logic [NUM_W-1:0]  num_o,
	output logic [SIDE_W-1:0] side_o
);

	logic [DIV_W:0]    rem_sh;
	logic [DIV_W:0]    rem_dif;
	logic              ge;
	logic              valid_q;
	logic [DIV_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [SIDE_W-1:0] side_q;

	always_comb begin
		rem_sh  = {rem_i, num_i[NUM_W-1]};
		ge      = rem_sh >= {1'b0, divisor};
		rem_dif = rem_sh - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// quotient bits enter at the bottom as the numerator leaves at the top
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? rem_dif[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			num_q  <= {num_i[NUM_W-2:0], ge};
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign rem_o   = rem_q;
	assign num_o   = num_q;
	assign side_o  = side_q;

endmodule

// File: rtl/wtpg_taylor_cell.sv
// One bracket of the nested sine polynomial: b <= 1 - x2*b / (2k(2k+1)).
module wtpg_taylor_cell #(
	parameter int K      = 7,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid_i,
	input  logic [wtpg_pkg::X_W-1:0]  x_i,
	input  logic [wtpg_pkg::X2_W-1:0] x2_i,
	input  logic [wtpg_pkg::B_W-1:0]  b_i,
	input  logic [SIDE_W-1:0]         side_i,
	output logic                     valid_o,
	output logic [wtpg_pkg::X_W-1:0]  x_o,
	output logic [wtpg_pkg::X2_W-1:0] x2_o,
	output logic [wtpg_pkg::B_W-1:0]  b_o,
	output logic [SIDE_W-1:0]         side_o
);

	import wtpg_pkg::*;

	localparam int          DEN    = 2 * K * (2 * K + 1);
	localparam int          SHIFT  = 31 + $clog2(DEN);
	localparam logic [63:0] M_WIDE = (64'd1 << SHIFT) / DEN;
	localparam logic [31:0] RECIP  = M_WIDE[31:0];

	logic [62:0] prod_x2b;
	logic [63:0] prod_rcp;
	logic [31:0] qd;
	logic [31:0] rem;
	logic [31:0] quo;

	logic              valid_s1, valid_s2, valid_s3;
	logic [X_W-1:0]    x_s1, x_s2, x_s3;
	logic [X2_W-1:0]   x2_s1, x2_s2, x2_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	logic [31:0]       y_s1, y_s2;
	logic [31:0]       q0_s2;
	logic [B_W-1:0]    b_s3;

	always_comb begin
		prod_x2b = 63'(x2_i) * 63'(b_i);
		prod_rcp = 64'(y_s1) * 64'(RECIP);
		// reciprocal estimate is low by at most one
		qd       = q0_s2 * 32'(DEN);
		rem      = y_s2 - qd;
		quo      = (rem >= 32'(DEN)) ? q0_s2 + 32'd1 : q0_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1    <= prod_x2b[61:30];
			x_s1    <= x_i;
			x2_s1   <= x2_i;
			side_s1 <= side_i;

			q0_s2   <= 32'(prod_rcp >> SHIFT);
			y_s2    <= y_s1;
			x_s2    <= x_s1;
			x2_s2   <= x2_s1;
			side_s2 <= side_s1;

			b_s3    <= B_W'(32'(Q30_ONE) - quo);
			x_s3    <= x_s2;
			x2_s3   <= x2_s2;
			side_s3 <= side_s2;
		end
	end

	assign valid_o = valid_s3;
	assign x_o     = x_s3;
	assign x2_o    = x2_s3;
	assign b_o     = b_s3;
	assign side_o  = side_s3;

endmodule

// File: rtl/wave_table_point_generator_core.sv
// Top level of the wave table point generator: config, cell chains, scaling.
// Usage:
//   Configuration is written through wr_en / wr_index / wr_data, one register
//   per cycle, only while no point is in flight.
//   s_tdata carries point_index; each transfer on s gives one sample on m.
//   m_tdata carries the sample, sign extended to 32 bits in 16-bit format.
// Pipeline: a chain of modulo cells, one bit each, a thirty-cell fraction
//   divider, seven three-stage polynomial cells and the scaling stages
//   lie between the input transfer and m_tvalid.
// Throughput: one point per cycle; the whole chain advances together.
// Stall: while m_tvalid is high and m_tready low, every cell holds its
//   contents and s_tready is low; s_tready is high whenever the output
//   register is empty or being emptied.
// Reset: arst_n clears all valid flags and loads the register defaults
//   (sine, 16-bit, period 1024, offset 0, low 0, high 32767).
`include "wave_table_point_generator_core_defines.svh"

module wave_table_point_generator_core #(
	parameter int INDEX_BITS          = wtpg_pkg::INDEX_BITS_DEF,
	parameter int LEVEL_FRACTION_BITS = wtpg_pkg::LEVEL_FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [wtpg_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [wtpg_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((INDEX_BITS+7)/8)*8-1:0]     s_tdata,  // [INDEX_BITS-1:0] point_index
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wtpg_pkg::SAMPLE_W-1:0]       m_tdata   // [31:0] sample
);

	import wtpg_pkg::*;

	localparam int LFB     = LEVEL_FRACTION_BITS;
	localparam int SUM_W   = ((INDEX_BITS > OFFSET_W) ? INDEX_BITS : OFFSET_W) + 1;
	localparam int NM      = SUM_W + 2;
	localparam int NU      = Q_FRAC;
	localparam int LVL_W   = LFB + 1;
	localparam int QF_W    = LFB + 2;
	localparam int TS_W    = LVL_W + 1;
	localparam int V_W     = LFB + 35;
	localparam int RND_W   = V_W - LFB + 1;
	localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(1) << LFB;

	// configuration registers
	wave_kind_t                  wave_kind_q;
	out_format_t                 out_format_q;
	logic [PERIOD_W-1:0]         period_q;
	logic [OFFSET_W-1:0]         offset_q;
	logic signed [SAMPLE_W-1:0]  low_q;
	logic signed [SAMPLE_W-1:0]  high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_kind_q  <= WAVE_SINE;
			out_format_q <= FMT_S16;
			period_q     <= PERIOD_RST;
			offset_q     <= '0;
			low_q        <= '0;
			high_q       <= HIGH_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_WAVE_KIND:     wave_kind_q  <= wave_kind_t'(wr_data[0]);
				REG_OUT_FORMAT:    out_format_q <= out_format_t'(wr_data[0]);
				REG_PERIOD_LENGTH: period_q     <= wr_data[PERIOD_W-1:0];
				REG_START_OFFSET:  offset_q     <= wr_data[OFFSET_W-1:0];
				REG_LOW_LEVEL:     low_q        <= signed'(wr_data);
				REG_HIGH_LEVEL:    high_q       <= signed'(wr_data);
				default: ;
			endcase
		end
	end

	logic [PERIOD_W-1:0] size;
	logic                en;

	// zero period behaves as a single point
	assign size     = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: phase sum
	logic             valid_s1;
	logic [SUM_W-1:0] sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= SUM_W'(s_tdata[INDEX_BITS-1:0]) + SUM_W'(offset_q);
		end
	end

	// modulo chain on {sum, 00}: after SUM_W cells the remainder is the point,
	// two more cells give quadrant and remainder of 4*point
	logic                mod_v    [0:NM];
	logic [PERIOD_W-1:0] mod_rem  [0:NM];
	logic [NM-1:0]       mod_num  [0:NM];
	logic [PERIOD_W-1:0] mod_side [0:NM];

	assign mod_v[0]    = valid_s1;
	assign mod_rem[0]  = '0;
	assign mod_num[0]  = {sum_s1, 2'b00};
	assign mod_side[0] = '0;

	for (genvar gi = 0; gi < NM; gi++) begin : g_mod
		wtpg_div_cell #(
			.NUM_W  (NM),
			.DIV_W  (PERIOD_W),
			.SIDE_W (PERIOD_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (mod_v[gi]),
			.divisor (size),
			.rem_i   (mod_rem[gi]),
			.num_i   (mod_num[gi]),
			.side_i  ((gi == SUM_W) ? mod_rem[gi] : mod_side[gi]),
			.valid_o (mod_v[gi+1]),
			.rem_o   (mod_rem[gi+1]),
			.num_o   (mod_num[gi+1]),
			.side_o  (mod_side[gi+1])
		);
	end

	// stage 2: numerator for the fraction divider
	logic [PERIOD_W-1:0] pt, rq, numv, init, n1;
	logic [1:0]          quad;
	logic [19:0]         four_p, s20, three_s, n;
	logic                a_ge, full;

	always_comb begin
		pt      = mod_side[NM];
		rq      = mod_rem[NM];
		quad    = mod_num[NM][1:0];
		four_p  = 20'(pt) << 2;
		s20     = 20'(size);
		three_s = s20 + (s20 << 1);
		numv    = quad[0] ? size - rq : rq;
		case (quad)
			2'd0:    n = four_p + s20;
			2'd3:    n = four_p - three_s;
			default: n = three_s - four_p;
		endcase
		a_ge = n >= s20;
		n1   = a_ge ? PERIOD_W'(n - s20) : PERIOD_W'(n);
		init = (wave_kind_q == WAVE_SINE) ? numv : n1;
		full = init == size;
	end

	logic                valid_s2;
	logic [PERIOD_W-1:0] rem_s2;
	logic [2:0]          side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= mod_v[NM];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2  <= full ? '0 : init;
			side_s2 <= {quad[1], a_ge, full};
		end
	end

	// fraction divider: thirty quotient bits of init * 2^30 / size
	logic                u_v    [0:NU];
	logic [PERIOD_W-1:0] u_rem  [0:NU];
	logic [NU-1:0]       u_num  [0:NU];
	logic [2:0]          u_side [0:NU];

	assign u_v[0]    = valid_s2;
	assign u_rem[0]  = rem_s2;
	assign u_num[0]  = '0;
	assign u_side[0] = side_s2;

	for (genvar gu = 0; gu < NU; gu++) begin : g_frac
		wtpg_div_cell #(
			.NUM_W  (NU),
			.DIV_W  (PERIOD_W),
			.SIDE_W (3)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (u_v[gu]),
			.divisor (size),
			.rem_i   (u_rem[gu]),
			.num_i   (u_num[gu]),
			.side_i  (u_side[gu]),
			.valid_o (u_v[gu+1]),
			.rem_o   (u_rem[gu+1]),
			.num_o   (u_num[gu+1]),
			.side_o  (u_side[gu+1])
		);
	end

	// stage 3: angle and triangle level
	logic [U_W-1:0]  uval;
	logic [61:0]     prod_ux;
	logic [QF_W-1:0] qf1;

	always_comb begin
		uval    = u_side[NU][0] ? Q30_ONE : {1'b0, u_num[NU]};
		prod_ux = 62'(uval) * 62'(HALF_PI_Q30);
		// level = (floor(n * 2^F / size) + 1) / 2
		qf1     = (QF_W'(u_side[NU][1]) << LFB) + QF_W'(uval >> (Q_FRAC - LFB))
			+ QF_W'(1);
	end

	logic            valid_s3;
	logic [X_W-1:0]  x_s3;
	logic [TS_W-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= u_v[NU];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= prod_ux[60:30];
			side_s3 <= {u_side[NU][2], qf1[LFB+1:1]};
		end
	end

	// stage 4: x squared
	logic [61:0]     prod_xx;
	logic            valid_s4;
	logic [X_W-1:0]  x_s4;
	logic [X2_W-1:0] x2_s4;
	logic [TS_W-1:0] side_s4;

	assign prod_xx = 62'(x_s3) * 62'(x_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4    <= x_s3;
			x2_s4   <= prod_xx[61:30];
			side_s4 <= side_s3;
		end
	end

	// polynomial brackets, innermost first
	logic            t_v    [0:TAYLOR_TERMS];
	logic [X_W-1:0]  t_x    [0:TAYLOR_TERMS];
	logic [X2_W-1:0] t_x2   [0:TAYLOR_TERMS];
	logic [B_W-1:0]  t_b    [0:TAYLOR_TERMS];
	logic [TS_W-1:0] t_side [0:TAYLOR_TERMS];

	assign t_v[0]    = valid_s4;
	assign t_x[0]    = x_s4;
	assign t_x2[0]   = x2_s4;
	assign t_b[0]    = Q30_ONE;
	assign t_side[0] = side_s4;

	for (genvar gt = 0; gt < TAYLOR_TERMS; gt++) begin : g_poly
		wtpg_taylor_cell #(
			.K      (TAYLOR_TERMS - gt),
			.SIDE_W (TS_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (t_v[gt]),
			.x_i     (t_x[gt]),
			.x2_i    (t_x2[gt]),
			.b_i     (t_b[gt]),
			.side_i  (t_side[gt]),
			.valid_o (t_v[gt+1]),
			.x_o     (t_x[gt+1]),
			.x2_o    (t_x2[gt+1]),
			.b_o     (t_b[gt+1]),
			.side_o  (t_side[gt+1])
		);
	end

	// stage 5: sine of the quarter angle
	logic [61:0]     prod_xb;
	logic            valid_s5;
	logic [31:0]     s_s5;
	logic [TS_W-1:0] side_s5;

	assign prod_xb = 62'(t_x[TAYLOR_TERMS]) * 62'(t_b[TAYLOR_TERMS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= t_v[TAYLOR_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5    <= prod_xb[61:30];
			side_s5 <= t_side[TAYLOR_TERMS];
		end
	end

	// stage 6: level in [0, 2^F]
	logic [32:0]      t_sum, t_rnd;
	logic [LVL_W-1:0] sine_lvl;
	logic             valid_s6;
	logic [LVL_W-1:0] level_s6;

	always_comb begin
		t_sum    = side_s5[TS_W-1] ? 33'(Q30_ONE) - 33'(s_s5) : 33'(Q30_ONE) + 33'(s_s5);
		t_rnd    = t_sum + (33'(1) << (Q_FRAC - LFB));
		sine_lvl = LVL_W'(t_rnd >> (Q_FRAC + 1 - LFB));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_s6 <= (wave_kind_q == WAVE_SINE) ? sine_lvl : side_s5[LVL_W-1:0];
		end
	end

	// stage 7: level * (high - low)
	logic signed [32:0]    diff;
	logic signed [V_W-1:0] prod_s7;
	logic                  valid_s7;

	assign diff = 33'(high_q) - 33'(low_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= V_W'(signed'({1'b0, level_s6})) * V_W'(diff);
		end
	end

	// stage 8: add the low level at the level scale
	logic signed [V_W-1:0] low_ext;
	logic signed [V_W-1:0] v_s8;
	logic                  valid_s8;

	assign low_ext = V_W'(low_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s8 <= (low_ext <<< LFB) + prod_s7;
		end
	end

	// stage 9: magnitude and sign
	logic           valid_s9;
	logic           neg_s9;
	logic [V_W-1:0] mag_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s9 <= v_s8[V_W-1];
			mag_s9 <= v_s8[V_W-1] ? V_W'(-v_s8) : V_W'(v_s8);
		end
	end

	// output register: round half away from zero, saturate
	logic [V_W:0]            mag_rnd;
	logic [RND_W-1:0]        rnd;
	logic signed [RND_W:0]   sr, lo_lim, hi_lim, sat;

	always_comb begin
		mag_rnd = {1'b0, mag_s9} + ((V_W+1)'(1) << (LFB - 1));
		rnd     = mag_rnd[V_W:LFB];
		sr      = neg_s9 ? -signed'({1'b0, rnd}) : signed'({1'b0, rnd});
		lo_lim  = (out_format_q == FMT_S16) ? (RND_W+1)'(S16_MIN) : (RND_W+1)'(S32_MIN);
		hi_lim  = (out_format_q == FMT_S16) ? (RND_W+1)'(S16_MAX) : (RND_W+1)'(S32_MAX);
		if (sr < lo_lim) begin
			sat = lo_lim;
		end else if (sr > hi_lim) begin
			sat = hi_lim;
		end else begin
			sat = sr;
		end
	end

	logic                m_tvalid_q;
	logic [SAMPLE_W-1:0] m_tdata_q;
	out_format_t         out_fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= sat[SAMPLE_W-1:0];
			out_fmt_q <= out_format_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`WTPG_ASSERT_NOW(a_s16_range, m_tvalid && (out_fmt_q == FMT_S16), (m_tdata[31:15] == '0) || (m_tdata[31:15] == '1))
	`WTPG_ASSERT_NEXT(a_stall_hold, valid_s9 && m_tvalid && !m_tready, valid_s9 && $stable(mag_s9))
	`WTPG_ASSERT_NOW(a_level_max, valid_s6, level_s6 <= LVL_MAX)

endmodule

// File: verif/tb_wave_table_point_generator_core.sv
// Self-checking testbench for the wave table point generator core.
`timescale 1ns / 100ps

module tb_wave_table_point_generator_core;
	import wtpg_pkg::*;

	localparam int LF = LEVEL_FRACTION_BITS_DEF;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;  // [15:0] point_index
	logic                  m_tvalid;
	logic                  m_tready;
	logic [SAMPLE_W-1:0]   m_tdata;  // [31:0] sample

	wave_table_point_generator_core dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// shadow copy of the registers
	wave_kind_t        sh_kind;
	out_format_t       sh_fmt;
	logic [16:0]       sh_period;
	logic [15:0]       sh_offset;
	logic signed [31:0] sh_low;
	logic signed [31:0] sh_high;

	logic signed [31:0] pending_samples[$];
	int                 errors;
	int                 burst_left;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	initial begin
		#2000000;
		$display("wave_table_point_generator_core regression: fail");
		$finish;
	end

	// sin(pi/2*u), u and result in Q30, truncating at each step
	function automatic longint unsigned quarter_sine_q30(longint unsigned u);
		longint unsigned x, x2, b, den;
		x = (u * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		b = 64'd1 << 30;
		for (int k = 7; k >= 1; k--) begin
			den = (2 * k) * (2 * k + 1);
			b = (64'd1 << 30) - ((x2 * b) >> 30) / den;
		end
		return (x * b) >> 30;
	endfunction

	function automatic logic signed [31:0] predict_sample(logic [15:0] idx);
		longint unsigned size, p, q, r, num, s, t, n, lvl, mag;
		longint signed   v, res, lo, hi, diff;
		size = (sh_period == 0) ? 1 : sh_period;
		p = (longint'(idx) + sh_offset) % size;
		q = (4 * p) / size;
		r = 4 * p - q * size;
		if (sh_kind == WAVE_SINE) begin
			num = (q == 1 || q == 3) ? size - r : r;
			s = quarter_sine_q30((num << 30) / size);
			t = (q >= 2) ? (64'd1 << 30) - s : (64'd1 << 30) + s;
			lvl = (t + (64'd1 << (30 - LF))) >> (31 - LF);
		end else begin
			if (q == 0)      n = 4 * p + size;
			else if (q == 3) n = 4 * p - 3 * size;
			else             n = 3 * size - 4 * p;
			lvl = ((n << LF) + size) / (2 * size);
		end
		diff = longint'(sh_high) - longint'(sh_low);
		v = longint'(sh_low) * (64'sd1 <<< LF) + longint'(lvl) * diff;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'd1 << (LF - 1))) >> LF;
		res = (v < 0) ? -longint'(mag) : longint'(mag);
		lo = (sh_fmt == FMT_S16) ? longint'(S16_MIN) : longint'(S32_MIN);
		hi = (sh_fmt == FMT_S16) ? longint'(S16_MAX) : longint'(S32_MAX);
		if (res < lo) res = lo;
		if (res > hi) res = hi;
		return res[31:0];
	endfunction

	// output side: check every transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				$error("sample: unexpected transfer, actual %0d", $signed(m_tdata));
				errors++;
			end else begin
				logic signed [31:0] want;
				want = pending_samples.pop_front();
				if (m_tdata !== want) begin
					$error("sample: expected %0d, actual %0d", want, $signed(m_tdata));
					errors++;
				end
			end
		end
	end

	// receiver stall pattern: alternating free-flowing and choppy stretches
	int stall_phase;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase[8])
			m_tready <= ($urandom_range(0, 9) > 3);
		else if (stall_phase[7])
			m_tready <= (stall_phase[3:0] != 4'd5);
		else
			m_tready <= 1'b1;
	end

	task automatic wait_idle();
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			REG_WAVE_KIND:     sh_kind = wave_kind_t'(val[0]);
			REG_OUT_FORMAT:    sh_fmt = out_format_t'(val[0]);
			REG_PERIOD_LENGTH: sh_period = val[16:0];
			REG_START_OFFSET:  sh_offset = val[15:0];
			REG_LOW_LEVEL:     sh_low = val;
			REG_HIGH_LEVEL:    sh_high = val;
			default: ;
		endcase
	endtask

	task automatic set_wave(wave_kind_t k, out_format_t f, logic [16:0] per,
			logic [15:0] off, logic [31:0] lo, logic [31:0] hi);
		// no transfers while the registers change
		s_tvalid <= 1'b0;
		wait_idle();
		write_reg(REG_WAVE_KIND, {31'd0, k});
		write_reg(REG_OUT_FORMAT, {31'd0, f});
		write_reg(REG_PERIOD_LENGTH, {15'd0, per});
		write_reg(REG_START_OFFSET, {16'd0, off});
		write_reg(REG_LOW_LEVEL, lo);
		write_reg(REG_HIGH_LEVEL, hi);
		wr_en <= 1'b0;
	endtask

	// one input transfer; random bursts with gaps in between
	task automatic send_point(logic [15:0] idx);
		s_tvalid <= 1'b1;
		s_tdata  <= idx;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		pending_samples.push_back(predict_sample(idx));
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_corners();
		logic [16:0] per;
		per = (sh_period == 0) ? 17'd1 : sh_period;
		send_point(16'd0);
		send_point(16'(per / 4));
		send_point(16'(per / 2));
		send_point(16'((3 * per) / 4));
	endtask

	task automatic test_reset_defaults();
		send_corners();
		send_point(16'hffff);
	endtask

	task automatic test_directed_corners();
		set_wave(WAVE_TRIANGLE, FMT_S32, 17'd1024, 16'd0, S32_MIN, S32_MAX);
		send_corners();
		// low above high: inverted wave, saturating in 16-bit format
		set_wave(WAVE_SINE, FMT_S16, 17'd7, 16'hffff, 32'sd100000, -32'sd100000);
		send_corners();
		// zero period acts as one point
		set_wave(WAVE_SINE, FMT_S32, 17'd0, 16'd5, -32'sd3, 32'sd9);
		send_point(16'h1234);
		set_wave(WAVE_TRIANGLE, FMT_S16, 17'h10000, 16'hffff, S32_MAX, S32_MIN);
		send_corners();
		send_point(16'hffff);
		set_wave(WAVE_SINE, FMT_S32, 17'd1, 16'd0, 32'sd0, 32'sd1);
		send_point(16'h5555);
	endtask

	task automatic test_random_points();
		logic [16:0] per;
		logic [31:0] lo, hi;
		for (int ph = 0; ph < 14; ph++) begin
			case ($urandom_range(0, 3))
				0: per = 17'($urandom_range(0, 64));
				1: per = 17'h10000;
				default: per = 17'($urandom_range(1, 65536));
			endcase
			lo = $urandom;
			hi = $urandom;
			if ($urandom_range(0, 1)) begin
				lo = 32'($signed(lo) >>> 14);
				hi = 32'($signed(hi) >>> 14);
			end
			set_wave(wave_kind_t'($urandom_range(0, 1)), out_format_t'($urandom_range(0, 1)),
				per, 16'($urandom), lo, hi);
			repeat (130) send_point(16'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_WAVE_KIND;
		wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		stall_phase = 0;
		errors = 0;
		burst_left = 0;
		sh_kind = WAVE_SINE;
		sh_fmt = FMT_S16;
		sh_period = PERIOD_RST;
		sh_offset = '0;
		sh_low = '0;
		sh_high = HIGH_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_corners();
		test_random_points();

		s_tvalid <= 1'b0;
		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("wave_table_point_generator_core regression: pass");
		else
			$display("wave_table_point_generator_core regression: fail");
		$finish;
	end

endmodule
